### rtl/core/tlat_pkg.sv
// Package for the trip latency average table: sizes, operation codes, state
// encoding, the core's record types and the structs shared with its divider.
// No dependencies.
package tlat_pkg;

  // Table sizes. Both counts are powers of two so a pair index is a concatenation.
  localparam int TAG_COUNT     = 256;
  localparam int STATION_COUNT = 64;
  localparam int TAG_W         = $clog2(TAG_COUNT);
  localparam int STATION_W     = $clog2(STATION_COUNT);
  localparam int PAIR_W        = 2 * STATION_W;

  // Field widths of the words on the ports.
  localparam int FUNC_W     = 2;
  localparam int STAMP_W    = 32;
  localparam int TOTAL_W    = 48;
  localparam int COUNT_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int AVG_W      = 48;
  localparam int DIVIDEND_W = TOTAL_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Operation codes carried on in_func.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  // Sequencer states of the core.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_END_RD,
    ST_END_UPD,
    ST_Q_RD,
    ST_Q_DIV
  } state_t;

  // One open trip record, indexed by tag.
  typedef struct packed {
    logic [STATION_W-1:0] station;
    logic [STAMP_W-1:0]   stamp;
  } open_rec_t;

  // One station pair record, indexed by {start station, end station}.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } pair_rec_t;

  // Request to the divider: launch strobe and operands.
  typedef struct packed {
    logic               go;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } div_req_t;

  // Response from the divider: completion strobe and saturated quotient.
  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/core/tlat_div.sv
// Bit-serial restoring divider for the average query: (total << 16) / count.
// Depends on tlat_pkg for widths and the request and response structs.
module tlat_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tlat_pkg::div_req_t req,
  output tlat_pkg::div_rsp_t rsp
);

  logic                             run_r;
  logic                             done_r;
  logic [tlat_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [tlat_pkg::DIVIDEND_W-1:0]  sh_r;
  logic [tlat_pkg::COUNT_W-1:0]     rem_r;
  logic [tlat_pkg::COUNT_W-1:0]     div_r;
  logic [tlat_pkg::COUNT_W:0]       trial;
  logic [tlat_pkg::COUNT_W:0]       diff;
  logic                             fits;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  assign trial = {rem_r, sh_r[tlat_pkg::DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  // Step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= tlat_pkg::DIV_CNT_W'(tlat_pkg::DIVIDEND_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == tlat_pkg::DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits as it empties.
  always_ff @(posedge clk) begin
    if (req.go) begin
      sh_r  <= {req.total, tlat_pkg::FRAC_W'(0)};
      rem_r <= '0;
      div_r <= req.count;
    end else if (run_r) begin
      sh_r  <= {sh_r[tlat_pkg::DIVIDEND_W-2:0], fits};
      rem_r <= fits ? diff[tlat_pkg::COUNT_W-1:0] : trial[tlat_pkg::COUNT_W-1:0];
    end
  end

  // A quotient that does not fit in the result width saturates.
  assign rsp.done = done_r;
  assign rsp.quot = (|sh_r[tlat_pkg::DIVIDEND_W-1:tlat_pkg::AVG_W]) ? '1
                                                                   : sh_r[tlat_pkg::AVG_W-1:0];

endmodule

### rtl/core/trip_latency_average_table_core.sv
// Trip latency average table: open trip records per tag and per-pair totals.
// Depends on tlat_pkg and instantiates tlat_div.
//
// Usage: drive in_func, in_tag, in_station, in_from_station and in_stamp and
// raise start; the word is taken at a clock edge where start is high and busy
// is low. A start operation writes the tag's record. An end operation reads
// the record and, if the tag has an open trip, reads the station pair entry
// and writes the pair back. A query reads the pair entry; with no trips the
// result is a zero average, otherwise the 64-step serial divider sets the
// figure. Only queries produce a result word: out_valid is high for exactly
// one cycle with out_average (unsigned Q32.16) and out_has_trips. The receiver
// cannot stall, so the result is taken in that cycle. One operation is in
// flight at a time, so no entry is read while a write to it is pending.
// After reset, busy stays high while every pair table entry is swept to zero;
// the open-record valid bits clear at once.
module trip_latency_average_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tlat_pkg::FUNC_W-1:0]     in_func,
  input  logic [tlat_pkg::TAG_W-1:0]      in_tag,
  input  logic [tlat_pkg::STATION_W-1:0]  in_station,
  input  logic [tlat_pkg::STATION_W-1:0]  in_from_station,
  input  logic [tlat_pkg::STAMP_W-1:0]    in_stamp,
  output logic                            out_valid,
  output logic [tlat_pkg::AVG_W-1:0]      out_average,
  output logic                            out_has_trips
);

  localparam int PAIR_DEPTH = tlat_pkg::STATION_COUNT * tlat_pkg::STATION_COUNT;

  tlat_pkg::state_t                   state_r, state_nxt;
  logic [tlat_pkg::PAIR_W-1:0]        clr_idx_r;
  logic [tlat_pkg::TAG_COUNT-1:0]     open_valid_r;
  logic                               vld_r;
  logic [tlat_pkg::STATION_W-1:0]     station_r;
  logic [tlat_pkg::STAMP_W-1:0]       stamp_r;
  logic [tlat_pkg::STAMP_W-1:0]       elapsed_r;
  logic [tlat_pkg::PAIR_W-1:0]        pair_addr_r;
  logic                               out_valid_r;
  logic [tlat_pkg::AVG_W-1:0]         out_average_r;
  logic                               out_has_trips_r;

  // Memories and their registered read data.
  tlat_pkg::open_rec_t                open_mem [tlat_pkg::TAG_COUNT];
  tlat_pkg::pair_rec_t                pair_mem [PAIR_DEPTH];
  tlat_pkg::open_rec_t                open_q;
  tlat_pkg::pair_rec_t                pair_q;

  // Control decoded from the state.
  logic                               accept;
  logic                               open_we;
  logic                               open_re;
  logic                               pair_re;
  logic [tlat_pkg::PAIR_W-1:0]        pair_raddr;
  logic                               pair_we;
  logic [tlat_pkg::PAIR_W-1:0]        pair_waddr;
  tlat_pkg::pair_rec_t                pair_wdata;
  logic                               out_load;
  logic                               out_hit;
  tlat_pkg::div_req_t                 div_req;
  tlat_pkg::div_rsp_t                 div_rsp;

  // Saturating update of a pair entry.
  logic [tlat_pkg::TOTAL_W:0]         sum;
  tlat_pkg::pair_rec_t                upd;

  assign accept = start && (state_r == tlat_pkg::ST_IDLE);
  assign busy   = (state_r != tlat_pkg::ST_IDLE);

  assign sum       = {1'b0, pair_q.total} + (tlat_pkg::TOTAL_W + 1)'(elapsed_r);
  assign upd.total = sum[tlat_pkg::TOTAL_W] ? '1 : sum[tlat_pkg::TOTAL_W-1:0];
  assign upd.count = (&pair_q.count) ? pair_q.count : pair_q.count + 1'b1;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlat_pkg::ST_CLEAR: begin
        if (&clr_idx_r) state_nxt = tlat_pkg::ST_IDLE;
      end
      tlat_pkg::ST_IDLE: begin
        if (start) begin
          unique case (tlat_pkg::func_t'(in_func))
            tlat_pkg::FUNC_END:   state_nxt = tlat_pkg::ST_END_RD;
            tlat_pkg::FUNC_QUERY: state_nxt = tlat_pkg::ST_Q_RD;
            default:              state_nxt = tlat_pkg::ST_IDLE;
          endcase
        end
      end
      tlat_pkg::ST_END_RD:  state_nxt = vld_r ? tlat_pkg::ST_END_UPD : tlat_pkg::ST_IDLE;
      tlat_pkg::ST_END_UPD: state_nxt = tlat_pkg::ST_IDLE;
      tlat_pkg::ST_Q_RD: begin
        state_nxt = (pair_q.count == '0) ? tlat_pkg::ST_IDLE : tlat_pkg::ST_Q_DIV;
      end
      tlat_pkg::ST_Q_DIV: begin
        if (div_rsp.done) state_nxt = tlat_pkg::ST_IDLE;
      end
      default: state_nxt = tlat_pkg::ST_IDLE;
    endcase
  end

  // Output logic: memory strobes, divider launch and result load.
  always_comb begin
    open_we       = 1'b0;
    open_re       = 1'b0;
    pair_re       = 1'b0;
    pair_raddr    = '0;
    pair_we       = 1'b0;
    pair_waddr    = pair_addr_r;
    pair_wdata    = upd;
    out_load      = 1'b0;
    out_hit       = 1'b0;
    div_req.go    = 1'b0;
    div_req.total = pair_q.total;
    div_req.count = pair_q.count;
    unique case (state_r)
      tlat_pkg::ST_CLEAR: begin
        pair_we    = 1'b1;
        pair_waddr = clr_idx_r;
        pair_wdata = '0;
      end
      tlat_pkg::ST_IDLE: begin
        if (start) begin
          unique case (tlat_pkg::func_t'(in_func))
            tlat_pkg::FUNC_START: open_we = 1'b1;
            tlat_pkg::FUNC_END:   open_re = 1'b1;
            tlat_pkg::FUNC_QUERY: begin
              pair_re    = 1'b1;
              pair_raddr = {in_from_station, in_station};
            end
            default: ;
          endcase
        end
      end
      tlat_pkg::ST_END_RD: begin
        pair_re    = vld_r;
        pair_raddr = {open_q.station, station_r};
      end
      tlat_pkg::ST_END_UPD: pair_we = 1'b1;
      tlat_pkg::ST_Q_RD: begin
        if (pair_q.count == '0) begin
          out_load = 1'b1;
        end else begin
          div_req.go = 1'b1;
        end
      end
      tlat_pkg::ST_Q_DIV: begin
        out_load = div_rsp.done;
        out_hit  = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers: state, clearing sweep, valid bits, result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tlat_pkg::ST_CLEAR;
      clr_idx_r    <= '0;
      open_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load;
      if (state_r == tlat_pkg::ST_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (open_we) open_valid_r[in_tag] <= 1'b1;
    end
  end

  // Operand capture and elapsed time, clamped at zero when the clock went back.
  always_ff @(posedge clk) begin
    if (accept) begin
      vld_r     <= open_valid_r[in_tag];
      station_r <= in_station;
      stamp_r   <= in_stamp;
    end
    if (pair_re) pair_addr_r <= pair_raddr;
    if (state_r == tlat_pkg::ST_END_RD) begin
      elapsed_r <= (stamp_r >= open_q.stamp) ? (stamp_r - open_q.stamp) : '0;
    end
    if (out_load) begin
      out_average_r   <= out_hit ? div_rsp.quot : '0;
      out_has_trips_r <= out_hit;
    end
  end

  // Open record memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (open_we) open_mem[in_tag] <= '{station: in_station, stamp: in_stamp};
    if (open_re) open_q <= open_mem[in_tag];
  end

  // Pair memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
    if (pair_re) pair_q <= pair_mem[pair_raddr];
  end

  tlat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid     = out_valid_r;
  assign out_average   = out_average_r;
  assign out_has_trips = out_has_trips_r;

  // A result word lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A query with no trips reports a zero average.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_trips) |-> (out_average == '0))
    else $error("nonzero average for an empty pair");

  // The divider only completes while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == tlat_pkg::ST_Q_DIV))
    else $error("divider finished outside a query");

  // A result word always follows a busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result produced without work in flight");

endmodule

### dv/tb_top.sv
// Testbench for trip_latency_average_table_core: directed and random trip words
// with a scoreboard that predicts every average-query result.
// Depends on tlat_pkg and the core RTL; needs no other files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlat_pkg::*;

  // Code 3 is unassigned: the block must swallow it without a result.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam logic [TOTAL_W-1:0] TICKS_CEIL = '1;
  localparam logic [COUNT_W-1:0] TRIPS_CEIL = '1;
  localparam logic [AVG_W-1:0] AVG_CEIL = '1;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             has_trips;
  } avg_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [FUNC_W-1:0]    in_func;
  logic [TAG_W-1:0]     in_tag;
  logic [STATION_W-1:0] in_station;
  logic [STATION_W-1:0] in_from_station;
  logic [STAMP_W-1:0]   in_stamp;
  logic                 out_valid;
  logic [AVG_W-1:0]     out_average;
  logic                 out_has_trips;

  // Shadow copy of the open trip records and the per-pair totals.
  bit                   trip_open [TAG_COUNT];
  bit [STATION_W-1:0]   trip_from [TAG_COUNT];
  bit [STAMP_W-1:0]     trip_t0 [TAG_COUNT];
  bit [TOTAL_W-1:0]     pair_ticks [STATION_COUNT*STATION_COUNT];
  bit [COUNT_W-1:0]     pair_trips [STATION_COUNT*STATION_COUNT];
  logic [PAIR_W-1:0]    travelled_pairs [$];

  avg_word_t expected_avgs [$];
  int unsigned fail_cnt = 0;

  trip_latency_average_table_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_tag          (in_tag),
    .in_station      (in_station),
    .in_from_station (in_from_station),
    .in_stamp        (in_stamp),
    .out_valid       (out_valid),
    .out_average     (out_average),
    .out_has_trips   (out_has_trips)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Count a failure; only the first ten are printed.
  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Update the shadow tables for one accepted word and queue any query answer.
  task automatic account_word(input logic [FUNC_W-1:0] func, input logic [TAG_W-1:0] tag,
                              input logic [STATION_W-1:0] station,
                              input logic [STATION_W-1:0] from_station,
                              input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] elapsed;
    logic [PAIR_W-1:0]  idx;
    logic [63:0]        scaled;
    avg_word_t          answer;
    case (func)
      FUNC_START: begin
        trip_open[tag] = 1'b1;
        trip_from[tag] = station;
        trip_t0[tag]   = stamp;
      end
      FUNC_END: begin
        if (trip_open[tag]) begin
          // A clock that ran backwards counts as a zero-length trip.
          elapsed = (stamp >= trip_t0[tag]) ? stamp - trip_t0[tag] : '0;
          idx = {trip_from[tag], station};
          if (pair_ticks[idx] > TICKS_CEIL - TOTAL_W'(elapsed)) begin
            pair_ticks[idx] = TICKS_CEIL;
          end else begin
            pair_ticks[idx] = pair_ticks[idx] + TOTAL_W'(elapsed);
          end
          if (pair_trips[idx] == '0) begin
            travelled_pairs.push_back(idx);
          end
          if (pair_trips[idx] != TRIPS_CEIL) begin
            pair_trips[idx] = pair_trips[idx] + 1'b1;
          end
        end
      end
      FUNC_QUERY: begin
        idx = {from_station, station};
        answer = '0;
        if (pair_trips[idx] != '0) begin
          scaled = {pair_ticks[idx], {FRAC_W{1'b0}}} / 64'(pair_trips[idx]);
          answer.average   = (scaled > 64'(AVG_CEIL)) ? AVG_CEIL : scaled[AVG_W-1:0];
          answer.has_trips = 1'b1;
        end
        expected_avgs.push_back(answer);
      end
      default: begin
      end
    endcase
  endtask

  // Present one word from the falling edge and hold it until it is taken.
  task automatic issue_word(input logic [FUNC_W-1:0] func, input logic [TAG_W-1:0] tag,
                            input logic [STATION_W-1:0] station,
                            input logic [STATION_W-1:0] from_station,
                            input logic [STAMP_W-1:0] stamp);
    @(negedge clk);
    start           <= 1'b1;
    in_func         <= func;
    in_tag          <= tag;
    in_station      <= station;
    in_from_station <= from_station;
    in_stamp        <= stamp;
    do begin
      @(posedge clk);
    end while (busy);
    account_word(func, tag, station, from_station, stamp);
  endtask

  // Drop start for a burst of idle cycles.
  task automatic rest_sender(input int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off new words until every pending answer has come back.
  task automatic wait_answers_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
  endtask

  // Random traffic: well-formed start/end pairs over a few busy stations, queries
  // mostly on pairs that have trips, plus stray ends and the spare code.
  task automatic drive_random_words(input int n_words, input bit allow_rest);
    int unsigned          pick;
    logic [FUNC_W-1:0]    f;
    logic [TAG_W-1:0]     tg;
    logic [STATION_W-1:0] st;
    logic [STATION_W-1:0] fr;
    logic [STAMP_W-1:0]   ts;
    logic [PAIR_W-1:0]    pr;
    for (int i = 0; i < n_words; i++) begin
      if (allow_rest && $urandom_range(0, 7) == 0) begin
        rest_sender($urandom_range(1, 15));
      end
      pick = $urandom_range(0, 99);
      tg = ($urandom_range(0, 1) != 0) ? TAG_W'($urandom_range(0, 15)) : TAG_W'($urandom());
      st = ($urandom_range(0, 2) == 0) ? STATION_W'($urandom())
                                       : STATION_W'($urandom_range(0, 5));
      fr = STATION_W'($urandom());
      ts = $urandom();
      if (pick < 38) begin
        f = FUNC_START;
      end else if (pick < 75) begin
        f = FUNC_END;
        if (trip_open[tg] && $urandom_range(0, 4) != 0) begin
          ts = trip_t0[tg] + STAMP_W'($urandom_range(0, 5000));
        end
      end else if (pick < 96) begin
        f = FUNC_QUERY;
        if (travelled_pairs.size() != 0 && $urandom_range(0, 3) != 0) begin
          pr = travelled_pairs[$urandom_range(0, travelled_pairs.size() - 1)];
          fr = pr[PAIR_W-1:STATION_W];
          st = pr[STATION_W-1:0];
        end
      end else begin
        f = FUNC_SPARE;
      end
      issue_word(f, tg, st, fr, ts);
    end
  endtask

  // Extreme tags, stations and stamps, including the full 32-bit elapsed time.
  task automatic test_field_extremes();
    issue_word(FUNC_START, 8'd0, 6'd0, 6'd63, 32'h0000_0000);
    issue_word(FUNC_END, 8'd0, 6'd63, 6'd0, 32'hFFFF_FFFF);
    issue_word(FUNC_QUERY, 8'd255, 6'd63, 6'd0, 32'hFFFF_FFFF);
    issue_word(FUNC_START, 8'd255, 6'd63, 6'd0, 32'h8000_0000);
    issue_word(FUNC_END, 8'd255, 6'd0, 6'd63, 32'hFFFF_FFFF);
    issue_word(FUNC_QUERY, 8'd0, 6'd0, 6'd63, 32'h0000_0000);
    issue_word(FUNC_START, 8'hAA, 6'h2A, 6'h15, 32'h5555_5555);
    issue_word(FUNC_END, 8'h55, 6'h15, 6'h2A, 32'hAAAA_AAAA);
    issue_word(FUNC_END, 8'hAA, 6'h15, 6'h2A, 32'hAAAA_AAAA);
    issue_word(FUNC_QUERY, 8'h55, 6'h15, 6'h2A, 32'h5555_5555);
    issue_word(FUNC_QUERY, 8'h00, 6'd63, 6'd63, 32'h0000_0000);
  endtask

  // Overwrite, stray end, repeated end, backwards clock, empty pair, spare code.
  task automatic test_record_rules();
    issue_word(FUNC_QUERY, 8'd0, 6'd0, 6'd0, 32'd0);
    issue_word(FUNC_END, 8'd7, 6'd12, 6'd0, 32'd400);
    issue_word(FUNC_START, 8'd7, 6'd5, 6'd0, 32'd100);
    issue_word(FUNC_START, 8'd7, 6'd9, 6'd0, 32'd200);
    issue_word(FUNC_END, 8'd7, 6'd12, 6'd0, 32'd260);
    issue_word(FUNC_QUERY, 8'd0, 6'd12, 6'd9, 32'd0);
    issue_word(FUNC_QUERY, 8'd0, 6'd12, 6'd5, 32'd0);
    issue_word(FUNC_END, 8'd7, 6'd12, 6'd0, 32'd263);
    issue_word(FUNC_QUERY, 8'd0, 6'd12, 6'd9, 32'd0);
    issue_word(FUNC_END, 8'd7, 6'd12, 6'd0, 32'd50);
    issue_word(FUNC_SPARE, 8'd7, 6'd12, 6'd9, 32'd999);
    issue_word(FUNC_QUERY, 8'd0, 6'd12, 6'd9, 32'd0);
  endtask

  // Pile maximal trips onto one pair so its total and average run large.
  task automatic test_large_totals();
    issue_word(FUNC_START, 8'd200, 6'd33, 6'd0, 32'h0000_0000);
    for (int i = 0; i < 60; i++) begin
      issue_word(FUNC_END, 8'd200, 6'd34, 6'd0, 32'hFFFF_FFFF);
    end
    issue_word(FUNC_QUERY, 8'd0, 6'd34, 6'd33, 32'd0);
    issue_word(FUNC_END, 8'd200, 6'd34, 6'd0, 32'hFFFF_FFFF);
    issue_word(FUNC_END, 8'd200, 6'd34, 6'd0, 32'hFFFF_FFFF);
    issue_word(FUNC_QUERY, 8'd0, 6'd34, 6'd33, 32'd0);
  endtask

  // Random traffic with idle bursts, and one pause until all answers are back.
  task automatic test_random_traffic();
    drive_random_words(800, 1'b1);
    wait_answers_drained();
    drive_random_words(800, 1'b1);
  endtask

  // Closing stretch with words offered on every cycle.
  task automatic test_back_to_back();
    drive_random_words(200, 1'b0);
  endtask

  // Compare every answer with the oldest prediction.
  always @(posedge clk) begin : answer_check
    avg_word_t want;
    if (rst_n && out_valid) begin
      if (expected_avgs.size() == 0) begin
        note_failure($sformatf("unexpected answer average=%h has_trips=%b",
                               out_average, out_has_trips));
      end else begin
        want = expected_avgs.pop_front();
        if (out_average !== want.average) begin
          note_failure($sformatf("average mismatch: expected %h, got %h",
                                 want.average, out_average));
        end
        if (out_has_trips !== want.has_trips) begin
          note_failure($sformatf("has_trips mismatch: expected %b, got %b",
                                 want.has_trips, out_has_trips));
        end
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    int unsigned settle_cnt;
    start           = 1'b0;
    in_func         = FUNC_START;
    in_tag          = '0;
    in_station      = '0;
    in_from_station = '0;
    in_stamp        = '0;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_record_rules();
    test_large_totals();
    test_random_traffic();
    test_back_to_back();

    @(negedge clk);
    start <= 1'b0;
    settle_cnt = 0;
    while (expected_avgs.size() != 0 && settle_cnt < 5000) begin
      @(posedge clk);
      settle_cnt++;
    end
    if (expected_avgs.size() != 0) begin
      note_failure($sformatf("%0d answers never arrived", expected_avgs.size()));
    end
    // Let any trailing operation finish.
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, table sweep included.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/core/tlat_pkg.sv
rtl/core/tlat_div.sv
rtl/core/trip_latency_average_table_core.sv
dv/tb_top.sv
